### sv/uart_tx_queue_with_parity_assert.svh
// Assertion macros shared by the transmit queue RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef UART_TX_QUEUE_WITH_PARITY_ASSERT_SVH
`define UART_TX_QUEUE_WITH_PARITY_ASSERT_SVH

// Checked outside reset only
`define UARTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included
`define UARTQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/uartq_pkg.sv
// Shared types, codes and the ninth-bit function of the UART transmit queue.
// No dependencies.
package uartq_pkg;

  // Command codes carried in the input tuser
  localparam logic CMD_ENQUEUE  = 1'b0;
  localparam logic CMD_TX_EVENT = 1'b1;

  // Configuration register indexes
  localparam logic CFG_IDX_PARITY    = 1'b0;
  localparam logic CFG_IDX_DIRECTION = 1'b1;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [1:0] {
    PAR_MARK  = 2'd0,
    PAR_SPACE = 2'd1,
    PAR_EVEN  = 2'd2,
    PAR_ODD   = 2'd3
  } par_mode_t;

  typedef struct packed {
    par_mode_t parity_mode;
    logic      direction_control;
  } uartq_cfg_t;

  // Ninth bit sent along with a byte
  function automatic logic ninth_bit(input logic [7:0] b, input par_mode_t m);
    logic p;
    p = ^b;
    case (m)
      PAR_MARK:  return 1'b1;
      PAR_SPACE: return 1'b0;
      PAR_EVEN:  return p;
      PAR_ODD:   return ~p;
      default:   return 1'b1;
    endcase
  endfunction

endpackage

### sv/uart_tx_queue_with_parity.sv
// UART transmit queue with ninth parity bit. One result per input transaction.
// The result is registered after the RAM read (ring read, then output register).
// A new transaction is not taken until the control unit has loaded the result of the
// previous one into the output register, which waits while the output is stalled.
// Reset (synchronous, rst_n low): pointers, flags and config clear; ring contents
// are left as they are and are only read after being written.
module uart_tx_queue_with_parity import uartq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte, [8] transmitter_ready, zero pad
  input  logic                  in_tuser,   // [0] cmd
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] accepted, [1] tx_valid, [9:2] tx_byte,
                                            // [10] tx_ninth_bit, [11] irq_enable,
                                            // [12] queue_finished, [13] drive_transmit, pad
  // config write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  uartq_cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  // Config register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_PARITY:    cfg_nxt.parity_mode       = par_mode_t'(cfg_data);
        CFG_IDX_DIRECTION: cfg_nxt.direction_control = cfg_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{parity_mode: PAR_MARK, direction_control: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  uartq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### sv/uartq_ram.sv
// Ring storage of the transmit queue: one write port, one registered read port.
// Depends on nothing but its parameters.
module uartq_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data_r
);

  logic [7:0] queue_mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue_mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= queue_mem_r[rd_addr];
    end
  end

endmodule

### sv/uartq_ctrl.sv
// Queue control: ring pointers, interrupt/finished/drive flags and output register.
// Depends on uartq_pkg and uartq_ram; assertions from uart_tx_queue_with_parity_assert.svh.
`include "uart_tx_queue_with_parity_assert.svh"

module uartq_ctrl import uartq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  uartq_cfg_t            cfg,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(QUEUE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOAD = 2'b10
  } state_t;

  // Status of one item held until the read data returns
  typedef struct packed {
    logic accepted;
    logic tx_valid;
    logic irq;
    logic finished;
    logic drive;
  } pend_t;

  state_t            state_r, state_nxt;
  pend_t             pend_r, pend_nxt;
  logic [ADDR_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              irq_r, irq_nxt;
  logic              fin_r, fin_nxt;
  logic              drive_r, drive_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic              in_fire;
  logic              load_out;
  logic [ADDR_W-1:0] wr_slot;
  logic [ADDR_W-1:0] rd_slot;
  logic              ring_full;
  logic              ring_empty;
  logic              mem_wr_en;
  logic              mem_rd_en;
  logic [7:0]        mem_rd_data;
  logic [7:0]        tx_byte;
  logic              tx_ninth;

  uartq_ram #(.DEPTH(QUEUE_DEPTH)) u_ram (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (wr_idx_r),
    .wr_data   (in_tdata[7:0]),
    .rd_en     (mem_rd_en),
    .rd_addr   (rd_idx_r),
    .rd_data_r (mem_rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign wr_slot    = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
  assign rd_slot    = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
  assign ring_full  = (wr_slot == rd_idx_r);
  assign ring_empty = (rd_idx_r == wr_idx_r);

  // Per-transaction update of pointers and flags
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    irq_nxt    = irq_r;
    fin_nxt    = fin_r;
    drive_nxt  = drive_r;
    mem_wr_en  = 1'b0;
    mem_rd_en  = 1'b0;
    pend_nxt   = pend_r;
    if (in_fire) begin
      pend_nxt.accepted = 1'b0;
      pend_nxt.tx_valid = 1'b0;
      if (in_tuser == CMD_ENQUEUE) begin
        if (!ring_full) begin
          mem_wr_en         = 1'b1;
          wr_idx_nxt        = wr_slot;
          pend_nxt.accepted = 1'b1;
        end
        // start sending when the transmitter idles with the interrupt off
        if (in_tdata[8] && !irq_r) begin
          irq_nxt = 1'b1;
          fin_nxt = 1'b0;
          if (cfg.direction_control) begin
            drive_nxt = 1'b1;
          end
        end
      end else begin
        if (ring_empty) begin
          irq_nxt   = 1'b0;
          fin_nxt   = 1'b1;
          drive_nxt = 1'b0;
        end else begin
          mem_rd_en         = 1'b1;
          rd_idx_nxt        = rd_slot;
          pend_nxt.tx_valid = 1'b1;
        end
      end
      pend_nxt.irq      = irq_nxt;
      pend_nxt.finished = fin_nxt;
      pend_nxt.drive    = drive_nxt;
    end
  end

  // Result assembly once the read data is back
  assign load_out = (state_r == S_LOAD) && (!out_valid_r || out_tready);
  assign tx_byte  = pend_r.tx_valid ? mem_rd_data : 8'h00;
  assign tx_ninth = pend_r.tx_valid ? ninth_bit(mem_rd_data, cfg.parity_mode) : 1'b0;

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    if (load_out) begin
      out_data_nxt  = {2'b00, pend_r.drive, pend_r.finished, pend_r.irq, tx_ninth,
                       tx_byte, pend_r.tx_valid, pend_r.accepted};
      out_valid_nxt = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_LOAD;
      S_LOAD:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      irq_r       <= 1'b0;
      fin_r       <= 1'b0;
      drive_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      irq_r       <= irq_nxt;
      fin_r       <= fin_nxt;
      drive_r     <= drive_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  `UARTQ_ASSERT(a_fire_to_load, in_fire |=> (state_r == S_LOAD), "accepted item did not go to load")
  `UARTQ_ASSERT(a_drive_needs_irq, drive_r |-> irq_r, "driver on while interrupt off")
  `UARTQ_ASSERT(a_fin_no_irq, fin_r |-> !irq_r, "finished while interrupt on")
  `UARTQ_ASSERT(a_idx_range, (rd_idx_r <= LAST_IDX) && (wr_idx_r <= LAST_IDX), "index out of ring")
  `UARTQ_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

### tb/uart_tx_queue_with_parity_tb.sv
// Testbench for the UART transmit queue: drives enqueue and transmitter-ready
// transactions and compares every result against an in-bench ring model.
// Depends on uartq_pkg and the uart_tx_queue_with_parity RTL.
module uart_tx_queue_with_parity_tb import uartq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 156;
  localparam int HOLD_AFTER  = 500;  // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES = 400;

  // One result transaction, fields in out_tdata order from the top bit down to bit 0
  typedef struct packed {
    logic [1:0] pad;
    logic       drive_transmit;
    logic       queue_finished;
    logic       irq_enable;
    logic       tx_ninth_bit;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       accepted;
  } tx_result_t;

  // Ring model plus the queue of results still owed by the block
  class tx_queue_scoreboard;
    logic [7:0] ring [RING_DEPTH];
    int         wr_ptr;
    int         rd_ptr;
    bit         irq_on;
    bit         finished;
    bit         drive_on;
    par_mode_t  parity_sel;
    bit         dir_ctrl;
    tx_result_t pending_results[$];
    int errors, n_items, n_stored, n_rejected, n_sent, n_drains, n_checked, n_settings;

    function new();
      wr_ptr = 0;
      rd_ptr = 0;
      irq_on = 0;
      finished = 0;
      drive_on = 0;
      parity_sel = PAR_MARK;
      dir_ctrl = 0;
    endfunction

    function void set_register(logic idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_IDX_PARITY) begin
        parity_sel = par_mode_t'(value);
      end else begin
        dir_ctrl = value[0];
      end
      n_settings++;
    endfunction

    // Ninth bit from a count of ones
    function logic parity_for(logic [7:0] data_val);
      int ones;
      ones = 0;
      for (int i = 0; i < 8; i++) ones += data_val[i];
      case (parity_sel)
        PAR_MARK:  return 1'b1;
        PAR_SPACE: return 1'b0;
        PAR_EVEN:  return ones[0];
        default:   return !ones[0];
      endcase
    endfunction

    function int next_slot(int ptr);
      return (ptr + 1 == RING_DEPTH) ? 0 : ptr + 1;
    endfunction

    // Advance the ring model by one accepted input transaction
    function void accept_item(logic cmd, logic [7:0] data_val, logic rdy);
      tx_result_t res;
      res = '0;
      n_items++;
      if (cmd == CMD_ENQUEUE) begin
        if (next_slot(wr_ptr) != rd_ptr) begin
          ring[wr_ptr] = data_val;
          wr_ptr = next_slot(wr_ptr);
          res.accepted = 1'b1;
          n_stored++;
        end else begin
          n_rejected++;
        end
        // start check is made even when the ring is full
        if (rdy && !irq_on) begin
          if (dir_ctrl) drive_on = 1;
          irq_on = 1;
          finished = 0;
        end
      end else if (rd_ptr == wr_ptr) begin
        irq_on = 0;
        finished = 1;
        drive_on = 0;
        n_drains++;
      end else begin
        res.tx_valid = 1'b1;
        res.tx_byte = ring[rd_ptr];
        res.tx_ninth_bit = parity_for(ring[rd_ptr]);
        rd_ptr = next_slot(rd_ptr);
        n_sent++;
      end
      res.irq_enable = irq_on;
      res.queue_finished = finished;
      res.drive_transmit = drive_on;
      pending_results.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task check_result(logic [OUT_DATA_W-1:0] word);
      tx_result_t got, want;
      got = word;
      if (pending_results.size() == 0) begin
        report($sformatf("result 0x%0h with nothing expected", word));
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      compare_field("accepted", got.accepted, want.accepted);
      compare_field("tx_valid", got.tx_valid, want.tx_valid);
      compare_field("tx_byte", got.tx_byte, want.tx_byte);
      compare_field("tx_ninth_bit", got.tx_ninth_bit, want.tx_ninth_bit);
      compare_field("irq_enable", got.irq_enable, want.irq_enable);
      compare_field("queue_finished", got.queue_finished, want.queue_finished);
      compare_field("drive_transmit", got.drive_transmit, want.drive_transmit);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [7:0] data_byte, [8] transmitter_ready, zero pad
  logic                  in_tuser;   // [0] cmd
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [0] accepted, [1] tx_valid, [9:2] tx_byte,
                                     // [10] tx_ninth_bit, [11] irq_enable,
                                     // [12] queue_finished, [13] drive_transmit, pad
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tx_queue_scoreboard sb;
  bit                 sender_calm;
  int                 cycle_count;

  uart_tx_queue_with_parity #(.QUEUE_DEPTH(RING_DEPTH)) dut (.*);

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, a few long ones
  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One input transaction; tvalid stays high into the next call when there is no gap
  task automatic send_item(input logic cmd, input logic [7:0] data_val, input logic rdy);
    int gap;
    if ($urandom_range(0, 99) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : gap_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_DATA_W - 9){1'b0}}, rdy, data_val};
    do @(posedge clk); while (!in_tready);
    sb.accept_item(cmd, data_val, rdy);
  endtask

  // Stop offering and wait until every result has come back
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // Write both registers back to back, valid held across the pair
  task automatic write_setting(input par_mode_t par, input logic dir);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_PARITY;
    cfg_data  <= par;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(CFG_IDX_PARITY, par);
    cfg_index <= CFG_IDX_DIRECTION;
    cfg_data  <= {1'b0, dir};
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(CFG_IDX_DIRECTION, {1'b0, dir});
    cfg_valid <= 1'b0;
  endtask

  // Random bursts: fill past full, drain past empty, or an even mix
  task automatic run_phase(input int n_items);
    int sent, burst_len, enq_pct;
    logic cmd;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 3))
        0: begin
          enq_pct = 92;
          burst_len = $urandom_range(60, 90);
        end
        1: begin
          enq_pct = 8;
          burst_len = $urandom_range(50, 80);
        end
        default: begin
          enq_pct = 50;
          burst_len = $urandom_range(10, 40);
        end
      endcase
      for (int k = 0; k < burst_len && sent < n_items; k++) begin
        cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_TX_EVENT;
        send_item(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off
  initial begin : receiver
    int hold;
    bit calm;
    bit held_off;
    hold = 0;
    calm = 0;
    held_off = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (!held_off && sb.n_checked >= HOLD_AFTER) begin
        hold = HOLD_CYCLES;
        held_off = 1'b1;
      end else if (hold == 0 && !calm && $urandom_range(0, 3) == 0) begin
        hold = gap_cycles();
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    par_mode_t phase_par [8];
    bit        phase_dir [8];
    phase_par = '{PAR_MARK, PAR_SPACE, PAR_EVEN, PAR_ODD, PAR_ODD, PAR_EVEN, PAR_SPACE,
                  PAR_MARK};
    phase_dir = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    sb = new();
    sender_calm = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_ENQUEUE;
    cfg_valid = 1'b0;
    cfg_index = CFG_IDX_PARITY;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-ring event, event with the interrupt off, start, drain
    write_setting(PAR_EVEN, 1'b1);
    send_item(CMD_TX_EVENT, 8'h00, 1'b0);
    send_item(CMD_ENQUEUE,  8'h00, 1'b0);
    send_item(CMD_TX_EVENT, 8'hFF, 1'b1);
    send_item(CMD_ENQUEUE,  8'hFF, 1'b1);
    send_item(CMD_ENQUEUE,  8'h01, 1'b1);
    send_item(CMD_ENQUEUE,  8'h80, 1'b0);
    send_item(CMD_ENQUEUE,  8'h7E, 1'b1);
    send_item(CMD_TX_EVENT, 8'h00, 1'b0);
    send_item(CMD_TX_EVENT, 8'h00, 1'b1);
    send_item(CMD_TX_EVENT, 8'hFF, 1'b0);
    send_item(CMD_TX_EVENT, 8'h00, 1'b0);
    send_item(CMD_TX_EVENT, 8'h00, 1'b0);
    send_item(CMD_ENQUEUE,  8'hA5, 1'b1);
    send_item(CMD_TX_EVENT, 8'h00, 1'b0);
    send_item(CMD_TX_EVENT, 8'h00, 1'b0);

    // Random phases, one register setting each
    for (int p = 0; p < 8; p++) begin
      quiesce();
      write_setting(phase_par[p], phase_dir[p]);
      run_phase(PHASE_ITEMS);
    end

    quiesce();
    repeat (8) @(posedge clk);
    $display("covered: %0d transactions in, %0d stored, %0d refused on a full ring, %0d sent,",
             sb.n_items, sb.n_stored, sb.n_rejected, sb.n_sent);
    $display("         %0d empty-ring drains, %0d register writes, %0d results compared",
             sb.n_drains, sb.n_settings, sb.n_checked);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
